// ===== hw/rtl/uyvy_scale_to_argb_unit_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef UYVY_SCALE_TO_ARGB_UNIT_ASSERT_SVH
`define UYVY_SCALE_TO_ARGB_UNIT_ASSERT_SVH

// Implication checked every clock while out of reset.
`define USTA_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Plain invariant checked every clock while out of reset.
`define USTA_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/usta_pkg.sv =====
// ----------------------------------------------------------------------------
// usta_pkg
// Shared types, constants and color helpers of the UYVY scaler.
// ----------------------------------------------------------------------------
package usta_pkg;

    localparam int DEF_MAX_OUT_WIDTH  = 1920;
    localparam int DEF_MAX_OUT_HEIGHT = 1300;
    localparam int DEF_MAX_SRC_DIM    = 4096;

    localparam int NUM_W = 24;   // 11-bit position times 13-bit size
    localparam int DIV_W = 11;   // clamped output size
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_ROW_STRIDE = 3'd2,
        CFG_OUT_WIDTH  = 3'd3,
        CFG_OUT_HEIGHT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [10:0] out_x;
        logic [10:0] out_y;
        logic [7:0]  chroma_u;
        logic [7:0]  luma_even;
        logic [7:0]  chroma_v;
        logic [7:0]  luma_odd;
    } req_t;

    typedef struct packed {
        logic [31:0] pixel_argb;
        logic [11:0] source_column;
        logic [11:0] source_row;
        logic [24:0] source_byte_offset;
    } res_t;

    typedef struct packed {
        logic [7:0] u;
        logic [7:0] y0;
        logic [7:0] v;
        logic [7:0] y1;
    } pix_t;

    typedef struct packed {
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        pix_t             pix;
    } work_t;

    typedef struct packed {
        logic [12:0] src_width;
        logic [12:0] src_height;
        logic [13:0] row_stride;
        logic [10:0] out_width;
        logic [10:0] out_height;
    } cfg_t;

    localparam logic [7:0] ALPHA = 8'hff;

    // floor(num / 256) clamped to 0..255
    function automatic logic [7:0] clamp_ch(input logic signed [19:0] num);
        logic signed [11:0] q;
        q = 12'(num >>> 8);
        if (q < 0)
            return 8'd0;
        else if (q > 12'sd255)
            return 8'd255;
        else
            return q[7:0];
    endfunction

endpackage

// ===== hw/rtl/usta_fifo.sv =====
// ----------------------------------------------------------------------------
// usta_fifo
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module usta_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  usta_pkg::work_t    wdata,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output usta_pkg::work_t    rdata
);

    usta_pkg::work_t mem [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_pop    = pop && not_empty;
    assign rdata     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/usta_front.sv =====
// ----------------------------------------------------------------------------
// usta_front
// Takes requests and forms the scaled numerators for the dividers.
// ----------------------------------------------------------------------------
module usta_front (
    input  logic             start,
    input  usta_pkg::req_t   req,
    input  logic             full,
    input  usta_pkg::cfg_t   cfg,
    output logic             busy,
    output logic             push,
    output usta_pkg::work_t  wdata
);

    assign busy = full;
    assign push = start && !full;

    always_comb
    begin
        wdata.num_x  = usta_pkg::NUM_W'(req.out_x * cfg.src_width);
        wdata.num_y  = usta_pkg::NUM_W'(req.out_y * cfg.src_height);
        wdata.pix.u  = req.chroma_u;
        wdata.pix.y0 = req.luma_even;
        wdata.pix.v  = req.chroma_v;
        wdata.pix.y1 = req.luma_odd;
    end

endmodule

// ===== hw/rtl/usta_div.sv =====
// ----------------------------------------------------------------------------
// usta_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module usta_div #(
    parameter int MAX_SRC_DIM = usta_pkg::DEF_MAX_SRC_DIM
) (
    input  logic                             clk,
    input  logic [usta_pkg::NUM_W-1:0]       num,
    input  logic [usta_pkg::DIV_W-1:0]       den,
    output logic [$clog2(MAX_SRC_DIM)-1:0]   quo
);

    localparam int QW = $clog2(MAX_SRC_DIM);
    localparam int NW = usta_pkg::NUM_W;
    localparam int DW = usta_pkg::DIV_W;
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;
    localparam logic [QW-1:0] QSAT = QW'(MAX_SRC_DIM - 1);

    logic [CW-1:0] rem_reg  [0:QW];
    logic [QW-1:0] quo_reg  [0:QW];
    logic          sat_reg  [0:QW];
    logic          zero_reg [0:QW];

    // num >= den * 2^QW means the quotient cannot fit
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= CW'(num);
        quo_reg[0]  <= '0;
        sat_reg[0]  <= (CW'(num >> QW) >= CW'(den)) && (den != '0);
        zero_reg[0] <= (den == '0);
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        localparam int BIT = QW - k;
        logic [CW-1:0] sub;
        assign sub = CW'(den) << BIT;

        always_ff @(posedge clk)
        begin
            sat_reg[k]  <= sat_reg[k-1];
            zero_reg[k] <= zero_reg[k-1];
            if (rem_reg[k-1] >= sub)
            begin
                rem_reg[k] <= rem_reg[k-1] - sub;
                quo_reg[k] <= quo_reg[k-1] | (QW'(1) << BIT);
            end
            else
            begin
                rem_reg[k] <= rem_reg[k-1];
                quo_reg[k] <= quo_reg[k-1];
            end
        end
    end

    always_comb
    begin
        priority if (zero_reg[QW])
            quo = '0;
        else if (sat_reg[QW] || (quo_reg[QW] > QSAT))
            quo = QSAT;
        else
            quo = quo_reg[QW];
    end

endmodule

// ===== hw/rtl/usta_back.sv =====
// ----------------------------------------------------------------------------
// usta_back
// Divides, picks luma, converts to ARGB and forms the macropixel address.
// ----------------------------------------------------------------------------
module usta_back #(
    parameter int MAX_OUT_WIDTH  = usta_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_OUT_HEIGHT = usta_pkg::DEF_MAX_OUT_HEIGHT,
    parameter int MAX_SRC_DIM    = usta_pkg::DEF_MAX_SRC_DIM
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  usta_pkg::work_t  in_work,
    input  usta_pkg::cfg_t   cfg,
    output logic             strobe,
    output usta_pkg::res_t   result
);

    localparam int QW = $clog2(MAX_SRC_DIM);
    localparam int PW = QW + 14;

    logic [usta_pkg::DIV_W-1:0] den_x, den_y;
    logic [QW-1:0]              qx, qy;

    always_comb
    begin
        den_x = ({2'b00, cfg.out_width} > 13'(MAX_OUT_WIDTH))
              ? usta_pkg::DIV_W'(MAX_OUT_WIDTH) : cfg.out_width;
        den_y = ({2'b00, cfg.out_height} > 13'(MAX_OUT_HEIGHT))
              ? usta_pkg::DIV_W'(MAX_OUT_HEIGHT) : cfg.out_height;
    end

    usta_div #(.MAX_SRC_DIM(MAX_SRC_DIM)) u_div_x (
        .clk (clk),
        .num (in_work.num_x),
        .den (den_x),
        .quo (qx)
    );

    usta_div #(.MAX_SRC_DIM(MAX_SRC_DIM)) u_div_y (
        .clk (clk),
        .num (in_work.num_y),
        .den (den_y),
        .quo (qy)
    );

    // side band follows the divider stages
    usta_pkg::pix_t pix_reg   [0:QW];
    logic           valid_reg [0:QW];

    always_ff @(posedge clk)
    begin
        pix_reg[0] <= in_work.pix;
        for (int k = 1; k <= QW; k++)
            pix_reg[k] <= pix_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                valid_reg[k] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= QW; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    // color sums and address product
    logic [7:0]         ysel, lum;
    logic signed [19:0] ls, us, vs;
    logic signed [19:0] r_next, g_next, b_next;
    logic signed [19:0] r_reg, g_reg, b_reg;
    logic [PW-1:0]      prod_reg;
    logic [QW-1:0]      col_reg, row_reg;
    logic               v1_reg, v2_reg;
    usta_pkg::res_t     res_reg;

    always_comb
    begin
        ysel   = qx[0] ? pix_reg[QW].y1 : pix_reg[QW].y0;
        lum    = (ysel < 8'd16) ? 8'd0 : ysel - 8'd16;
        ls     = $signed({12'd0, lum});
        us     = $signed({12'd0, pix_reg[QW].u}) - 20'sd128;
        vs     = $signed({12'd0, pix_reg[QW].v}) - 20'sd128;
        r_next = 20'sd298 * ls + 20'sd409 * vs + 20'sd128;
        g_next = 20'sd298 * ls - 20'sd100 * us - 20'sd208 * vs + 20'sd128;
        b_next = 20'sd298 * ls + 20'sd516 * us + 20'sd128;
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        g_reg    <= g_next;
        b_reg    <= b_next;
        prod_reg <= PW'(qy) * PW'(cfg.row_stride);
        col_reg  <= qx & ~QW'(1);
        row_reg  <= qy;

        res_reg.pixel_argb <= {usta_pkg::ALPHA, usta_pkg::clamp_ch(r_reg),
                               usta_pkg::clamp_ch(g_reg), usta_pkg::clamp_ch(b_reg)};
        res_reg.source_column      <= 12'(col_reg);
        res_reg.source_row         <= 12'(row_reg);
        res_reg.source_byte_offset <= 25'(prod_reg) + 25'({col_reg, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_reg[QW];
            v2_reg <= v1_reg;
        end
    end

    assign strobe = v2_reg;
    assign result = res_reg;

endmodule

// ===== hw/rtl/uyvy_scale_to_argb_unit.sv =====
// ----------------------------------------------------------------------------
// uyvy_scale_to_argb_unit
// Nearest-neighbour UYVY to ARGB scaler, one output pixel per clock.
// ----------------------------------------------------------------------------
// A request (start high while busy is low) carries an output position and the
// four bytes of its UYVY macropixel. One request is taken every clock; each
// gives exactly one result, shown on result for a single cycle with strobe
// high, in request order. The result is taken at the edge that ends that cycle.
// A request passes through the queue, the divider pipeline
// ($clog2(MAX_SRC_DIM) + 1 stages, fed straight from the queue) and then the
// color and address stages. The receiver cannot hold results off, so nothing
// backs up and busy stays low in normal use. The user must write configuration
// through cfg_valid/ready only while no request is in flight; the block itself
// does not enforce this, and cfg_ready is always high.
// ----------------------------------------------------------------------------
module uyvy_scale_to_argb_unit #(
    parameter int MAX_OUT_WIDTH  = usta_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_OUT_HEIGHT = usta_pkg::DEF_MAX_OUT_HEIGHT,
    parameter int MAX_SRC_DIM    = usta_pkg::DEF_MAX_SRC_DIM
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  usta_pkg::req_t                      req,
    output logic                                strobe,
    output usta_pkg::res_t                      result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [usta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [usta_pkg::CFG_DATA_W-1:0]     cfg_data
);

    usta_pkg::cfg_t  cfg_reg;
    usta_pkg::work_t wdata, rdata;
    logic            push, full, not_empty;

    assign cfg_ready = 1'b1;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= 13'd1920;
            cfg_reg.src_height <= 13'd1080;
            cfg_reg.row_stride <= 14'd3840;
            cfg_reg.out_width  <= 11'd1920;
            cfg_reg.out_height <= 11'd1080;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (usta_pkg::cfg_idx_t'(cfg_index))
                usta_pkg::CFG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_data[12:0];
                usta_pkg::CFG_SRC_HEIGHT: cfg_reg.src_height <= cfg_data[12:0];
                usta_pkg::CFG_ROW_STRIDE: cfg_reg.row_stride <= cfg_data[13:0];
                usta_pkg::CFG_OUT_WIDTH:  cfg_reg.out_width  <= cfg_data[10:0];
                usta_pkg::CFG_OUT_HEIGHT: cfg_reg.out_height <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // front: take request, form numerators
    usta_front u_front (
        .start (start),
        .req   (req),
        .full  (full),
        .cfg   (cfg_reg),
        .busy  (busy),
        .push  (push),
        .wdata (wdata)
    );

    // queue decouples front and back
    usta_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (wdata),
        .pop       (1'b1),
        .full      (full),
        .not_empty (not_empty),
        .rdata     (rdata)
    );

    // back: divide, convert, address; always drains the queue
    usta_back #(
        .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
        .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT),
        .MAX_SRC_DIM    (MAX_SRC_DIM)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (not_empty),
        .in_work  (rdata),
        .cfg      (cfg_reg),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

// ===== hw/rtl/usta_checker.sv =====
// ----------------------------------------------------------------------------
// usta_checker
// Port-level checks of the scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "uyvy_scale_to_argb_unit_assert.svh"

module usta_checker #(
    parameter int MAX_SRC_DIM = usta_pkg::DEF_MAX_SRC_DIM
) (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           strobe,
    input usta_pkg::res_t result
);

    // request edge to the edge that takes its result
    localparam int LAT = $clog2(MAX_SRC_DIM) + 4;

    logic accepted;
    logic alpha_ok;
    logic col_even;
    assign accepted = start && !busy;
    assign alpha_ok = (result.pixel_argb[31:24] == usta_pkg::ALPHA);
    assign col_even = !result.source_column[0];

    `USTA_ASSERT_IMP(a_alpha, clk, rst_n, strobe, alpha_ok, "alpha not opaque")
    `USTA_ASSERT_IMP(a_even_col, clk, rst_n, strobe, col_even, "column not even")
    `USTA_ASSERT_IMP(a_latency, clk, rst_n, accepted, ##LAT strobe, "result missing")
    `USTA_ASSERT_ALWAYS(a_no_busy, clk, rst_n, !busy, "queue backed up")

endmodule

bind uyvy_scale_to_argb_unit usta_checker #(.MAX_SRC_DIM(MAX_SRC_DIM)) u_usta_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
